[hdl/jats_pkg.sv]
// Shared types and constants of the job admission and time-slice scheduler.
// Used by jats_dp, jats_ctrl and job_admission_timeslice_scheduler.
package jats_pkg;

  localparam int JobSlotsDef = 16;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_STOP   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOJOB = 2'd2;

  localparam logic [1:0] CFG_MAX_BLOCKS  = 2'd0;
  localparam logic [1:0] CFG_MAX_JOBS    = 2'd1;
  localparam logic [1:0] CFG_BLK_LATENCY = 2'd2;

  localparam logic [15:0] MaxBlocksRst  = 16'd1;
  localparam logic [4:0]  MaxJobsRst    = 5'd1;
  localparam logic [15:0] BlkLatencyRst = 16'd60;

  typedef enum logic [1:0] {
    SLOT_SRC_SEL,
    SLOT_SRC_CMD,
    SLOT_SRC_ZERO,
    SLOT_SRC_ENQ
  } slot_src_e;

  // per-slot job record held in the slot memory
  typedef struct packed {
    logic [15:0] blocks;
    logic [7:0]  start_count;
    logic [31:0] start_tick;
    logic [31:0] stamp;
  } job_rec_t;

  typedef struct packed {
    logic        latch_in;
    logic        tick;
    logic        idx_clr;
    logic        idx_inc;
    logic        enq_write;
    logic        sel_from_idx;
    logic        sel_from_slot;
    logic        rd_slot;
    logic        load_rec;
    logic        pass_clr;
    logic        want_val;
    logic        srch_clr;
    logic        srch_run;
    logic        mark_seen;
    logic        do_start;
    logic        do_halt;
    logic        clr_valid;
    logic        mul1;
    logic        mul2;
    logic        emit;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic        last;
    slot_src_e   slot_src;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       free_here;
    logic       idx_last;
    logic       slot_ok;
    logic       sel_running;
    logic       srch_done;
    logic       best_found;
    logic       want;
    logic       can_start;
    logic       expired;
    logic       any_pending;
    logic       out_free;
  } status_t;

endpackage

[hdl/jats_dp.sv]
// Datapath: configuration registers, slot flags, slot memory, search, slice math, output register.
// Depends on jats_pkg; driven by jats_ctrl through cmd_t and reports through status_t.
module jats_dp #(
  parameter int JOB_SLOTS = jats_pkg::JobSlotsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jats_pkg::cmd_t    cmd_i,
  output jats_pkg::status_t sts_o,
  input  logic [1:0]        opcode_i,
  input  logic [3:0]        job_slot_i,
  input  logic [15:0]       block_count_i,
  input  logic              cfg_wr_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        event_kind_o,
  output logic [3:0]        event_slot_o,
  output logic [1:0]        status_o,
  output logic              last_o
);
  import jats_pkg::*;

  localparam int SLOT_W = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam int IDX_W  = $clog2(JOB_SLOTS + 1);

  logic [15:0] max_blocks_q;
  logic [4:0]  max_jobs_q;
  logic [15:0] blk_lat_q;

  logic [1:0]  op_q;
  logic [3:0]  slot_q;
  logic [15:0] blocks_q;

  logic [JOB_SLOTS-1:0] valid_q, running_q, seen_q;
  job_rec_t             mem_q [JOB_SLOTS];
  job_rec_t             rd_q, rec_q, wr_rec;
  logic                 wr_en;
  logic [SLOT_W-1:0]    rd_addr;

  logic [31:0] next_stamp_q, now_q;
  logic [19:0] blk_use_q;
  logic [4:0]  jobs_q;

  logic [IDX_W-1:0]  idx_q;
  logic [SLOT_W-1:0] pend_idx_q, sel_q, best_idx_q, enq_slot_q;
  logic              pend_v_q, best_v_q, want_q;
  logic [31:0]       best_age_q, age;
  logic              cand;

  logic [31:0] prod1_q;
  logic [39:0] prod2_q;
  logic [40:0] slice_end;

  logic [31:0] slot_wide, sel_wide, enq_wide;
  logic [SLOT_W-1:0] slot_idx;
  logic [20:0] blk_sum;
  logic [5:0]  jobs_inc;
  logic        out_valid_q;
  logic        out_free;
  logic [3:0]  ev_slot;

  assign slot_wide = 32'(slot_q);
  assign slot_idx  = slot_wide[SLOT_W-1:0];
  assign sel_wide  = 32'(sel_q);
  assign enq_wide  = 32'(enq_slot_q);
  assign rd_addr   = cmd_i.rd_slot ? slot_idx : idx_q[SLOT_W-1:0];

  assign age  = next_stamp_q - rd_q.stamp;
  assign cand = pend_v_q && valid_q[pend_idx_q] && (running_q[pend_idx_q] == want_q)
                && !seen_q[pend_idx_q];

  assign blk_sum   = {5'd0, rec_q.blocks} + {1'b0, blk_use_q};
  assign jobs_inc  = {1'b0, jobs_q} + 6'd1;
  assign slice_end = {9'd0, rec_q.start_tick} + {1'b0, prod2_q};
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    case (cmd_i.slot_src)
      SLOT_SRC_SEL: ev_slot = sel_wide[3:0];
      SLOT_SRC_CMD: ev_slot = slot_q;
      SLOT_SRC_ENQ: ev_slot = enq_wide[3:0];
      default:      ev_slot = 4'd0;
    endcase
  end

  always_comb begin
    wr_en  = 1'b0;
    wr_rec = rec_q;
    if (cmd_i.enq_write) begin
      wr_en  = 1'b1;
      wr_rec = '{blocks: blocks_q, start_count: 8'd0, start_tick: 32'd0,
                 stamp: next_stamp_q};
    end else if (cmd_i.do_start) begin
      wr_en = 1'b1;
      wr_rec.start_count = (rec_q.start_count == 8'hFF) ? 8'hFF : rec_q.start_count + 8'd1;
      wr_rec.start_tick  = now_q;
      wr_rec.stamp       = next_stamp_q;
    end else if (cmd_i.do_halt) begin
      wr_en        = 1'b1;
      wr_rec.stamp = next_stamp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[sel_q] <= wr_rec;
    end
    rd_q <= mem_q[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q     <= opcode_i;
      slot_q   <= job_slot_i;
      blocks_q <= block_count_i;
    end
    if (cmd_i.load_rec) begin
      rec_q <= rd_q;
    end else if (cmd_i.srch_run && cand && (!best_v_q || age > best_age_q)) begin
      rec_q <= rd_q;
    end
    if (cmd_i.mul1) prod1_q <= 32'(blk_lat_q) * 32'(rec_q.blocks);
    if (cmd_i.mul2) prod2_q <= 40'(prod1_q) * 40'(rec_q.start_count);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_blocks_q <= MaxBlocksRst;
      max_jobs_q   <= MaxJobsRst;
      blk_lat_q    <= BlkLatencyRst;
      valid_q      <= '0;
      running_q    <= '0;
      seen_q       <= '0;
      next_stamp_q <= '0;
      now_q        <= '0;
      blk_use_q    <= '0;
      jobs_q       <= '0;
      idx_q        <= '0;
      pend_idx_q   <= '0;
      pend_v_q     <= 1'b0;
      sel_q        <= '0;
      enq_slot_q   <= '0;
      best_idx_q   <= '0;
      best_v_q     <= 1'b0;
      best_age_q   <= '0;
      want_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      event_kind_o <= '0;
      event_slot_o <= '0;
      status_o     <= '0;
      last_o       <= 1'b0;
    end else begin
      if (cfg_wr_i) begin
        case (cfg_index_i)
          CFG_MAX_BLOCKS:  max_blocks_q <= cfg_data_i;
          CFG_MAX_JOBS:    max_jobs_q   <= cfg_data_i[4:0];
          CFG_BLK_LATENCY: blk_lat_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.tick && now_q != 32'hFFFF_FFFF) now_q <= now_q + 32'd1;

      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + IDX_W'(1);

      // hold the enqueued slot for the finish event; sel_q moves during the scan
      if (cmd_i.sel_from_idx) begin
        sel_q      <= idx_q[SLOT_W-1:0];
        enq_slot_q <= idx_q[SLOT_W-1:0];
      end
      if (cmd_i.sel_from_slot) sel_q <= slot_idx;

      if (cmd_i.enq_write) begin
        valid_q[sel_q]   <= 1'b1;
        running_q[sel_q] <= 1'b0;
        next_stamp_q     <= next_stamp_q + 32'd1;
      end

      if (cmd_i.pass_clr) begin
        seen_q <= '0;
        want_q <= cmd_i.want_val;
      end

      // walk all slots, one memory read per cycle, keep the oldest candidate
      if (cmd_i.srch_clr) begin
        idx_q    <= '0;
        pend_v_q <= 1'b0;
        best_v_q <= 1'b0;
      end else if (cmd_i.srch_run) begin
        if (idx_q != IDX_W'(JOB_SLOTS)) begin
          pend_v_q   <= 1'b1;
          pend_idx_q <= idx_q[SLOT_W-1:0];
          idx_q      <= idx_q + IDX_W'(1);
        end else begin
          pend_v_q <= 1'b0;
        end
        if (cand && (!best_v_q || age > best_age_q)) begin
          best_v_q   <= 1'b1;
          best_idx_q <= pend_idx_q;
          best_age_q <= age;
        end
      end

      if (cmd_i.mark_seen) begin
        sel_q              <= best_idx_q;
        seen_q[best_idx_q] <= 1'b1;
      end

      if (cmd_i.do_start) begin
        running_q[sel_q] <= 1'b1;
        blk_use_q        <= blk_sum[19:0];
        jobs_q           <= jobs_inc[4:0];
        next_stamp_q     <= next_stamp_q + 32'd1;
      end
      if (cmd_i.do_halt) begin
        running_q[sel_q] <= 1'b0;
        if (jobs_q != 5'd0) jobs_q <= jobs_q - 5'd1;
        blk_use_q    <= (blk_use_q >= {4'd0, rec_q.blocks}) ?
                        blk_use_q - {4'd0, rec_q.blocks} : 20'd0;
        next_stamp_q <= next_stamp_q + 32'd1;
      end
      if (cmd_i.clr_valid) begin
        valid_q[sel_q]   <= 1'b0;
        running_q[sel_q] <= 1'b0;
      end

      if (cmd_i.emit) begin
        out_valid_q  <= 1'b1;
        event_kind_o <= cmd_i.kind;
        event_slot_o <= ev_slot;
        status_o     <= cmd_i.status;
        last_o       <= cmd_i.last;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.op          = op_q;
    sts_o.free_here   = !valid_q[idx_q[SLOT_W-1:0]];
    sts_o.idx_last    = (idx_q == IDX_W'(JOB_SLOTS - 1));
    sts_o.slot_ok     = (slot_wide < 32'(JOB_SLOTS)) && valid_q[slot_idx];
    sts_o.sel_running = running_q[sel_q];
    sts_o.srch_done   = (idx_q == IDX_W'(JOB_SLOTS)) && !pend_v_q;
    sts_o.best_found  = best_v_q;
    sts_o.want        = want_q;
    sts_o.can_start   = (jobs_q == 5'd0) ||
                        ((blk_sum <= {5'd0, max_blocks_q}) && (jobs_inc <= {1'b0, max_jobs_q}));
    sts_o.expired     = !(slice_end > {9'd0, now_q});
    sts_o.any_pending = |(valid_q & ~running_q);
    sts_o.out_free    = out_free;
  end

  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free) else $error("event issued while output register busy");
  a_start_halt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.do_start && cmd_i.do_halt)) else $error("start and stop in one cycle");
  a_start_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_start |-> (valid_q[sel_q] && !running_q[sel_q]))
    else $error("start of a job that is not pending");
  a_halt_running : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_halt |-> running_q[sel_q]) else $error("stop of a job that is not running");

endmodule

[hdl/jats_ctrl.sv]
// Controller: sequences command decode, slot allocation, start and stop scans, events.
// Depends on jats_pkg; drives jats_dp through cmd_t.
module jats_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  jats_pkg::status_t sts_i,
  output jats_pkg::cmd_t    cmd_o
);
  import jats_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ENQ_FIND, S_ENQ_WR, S_DQ_CHK, S_DQ_RD, S_DQ_HALT,
    S_SCAN, S_SRCH, S_TRY_START, S_PEND_CHK, S_MUL1, S_MUL2, S_CHK_END,
    S_STOP, S_FIN
  } state_e;

  state_e    state_q, state_d;
  logic [1:0] fin_status_q, fin_status_d;
  slot_src_e fin_src_q, fin_src_d;

  always_comb begin
    state_d      = state_q;
    fin_status_d = fin_status_q;
    fin_src_d    = fin_src_q;
    cmd_o        = '0;
    cmd_o.slot_src = SLOT_SRC_SEL;
    in_stall_o   = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        fin_status_d = ST_OK;
        case (sts_i.op)
          OP_ENQ: begin
            fin_src_d     = SLOT_SRC_ENQ;
            cmd_o.idx_clr = 1'b1;
            state_d       = S_ENQ_FIND;
          end
          OP_DEQ: begin
            fin_src_d = SLOT_SRC_CMD;
            state_d   = S_DQ_CHK;
          end
          OP_TICK: begin
            fin_src_d  = SLOT_SRC_ZERO;
            cmd_o.tick = 1'b1;
            state_d    = S_SCAN;
          end
          default: begin
            fin_src_d = SLOT_SRC_ZERO;
            state_d   = S_FIN;
          end
        endcase
      end
      S_ENQ_FIND: begin
        if (sts_i.free_here) begin
          cmd_o.sel_from_idx = 1'b1;
          state_d = S_ENQ_WR;
        end else if (sts_i.idx_last) begin
          fin_status_d = ST_FULL;
          fin_src_d    = SLOT_SRC_ZERO;
          state_d      = S_FIN;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_ENQ_WR: begin
        cmd_o.enq_write = 1'b1;
        state_d = S_SCAN;
      end
      S_DQ_CHK: begin
        cmd_o.rd_slot = 1'b1;
        if (sts_i.slot_ok) begin
          cmd_o.sel_from_slot = 1'b1;
          state_d = S_DQ_RD;
        end else begin
          fin_status_d = ST_NOJOB;
          state_d      = S_FIN;
        end
      end
      S_DQ_RD: begin
        cmd_o.load_rec = 1'b1;
        state_d = S_DQ_HALT;
      end
      S_DQ_HALT: begin
        if (!sts_i.sel_running) begin
          cmd_o.clr_valid = 1'b1;
          state_d = S_SCAN;
        end else if (sts_i.out_free) begin
          cmd_o.do_halt   = 1'b1;
          cmd_o.clr_valid = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.kind      = KIND_STOP;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.pass_clr = 1'b1;
        cmd_o.want_val = 1'b0;
        cmd_o.srch_clr = 1'b1;
        state_d = S_SRCH;
      end
      S_SRCH: begin
        cmd_o.srch_run = 1'b1;
        if (sts_i.srch_done) begin
          if (sts_i.best_found) begin
            cmd_o.mark_seen = 1'b1;
            state_d = sts_i.want ? S_MUL1 : S_TRY_START;
          end else begin
            state_d = sts_i.want ? S_FIN : S_PEND_CHK;
          end
        end
      end
      S_TRY_START: begin
        if (!sts_i.can_start) begin
          cmd_o.srch_clr = 1'b1;
          state_d = S_SRCH;
        end else if (sts_i.out_free) begin
          cmd_o.do_start = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.kind     = KIND_START;
          cmd_o.srch_clr = 1'b1;
          state_d = S_SRCH;
        end
      end
      S_PEND_CHK: begin
        if (sts_i.any_pending) begin
          cmd_o.pass_clr = 1'b1;
          cmd_o.want_val = 1'b1;
          cmd_o.srch_clr = 1'b1;
          state_d = S_SRCH;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = S_CHK_END;
      end
      S_CHK_END: begin
        if (sts_i.expired) begin
          state_d = S_STOP;
        end else begin
          cmd_o.srch_clr = 1'b1;
          state_d = S_SRCH;
        end
      end
      S_STOP: begin
        if (sts_i.out_free) begin
          cmd_o.do_halt  = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.kind     = KIND_STOP;
          cmd_o.srch_clr = 1'b1;
          state_d = S_SRCH;
        end
      end
      S_FIN: begin
        cmd_o.slot_src = fin_src_q;
        if (sts_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.kind   = KIND_FINISH;
          cmd_o.status = fin_status_q;
          cmd_o.last   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fin_status_q <= ST_OK;
      fin_src_q    <= SLOT_SRC_ZERO;
    end else begin
      state_q      <= state_d;
      fin_status_q <= fin_status_d;
      fin_src_q    <= fin_src_d;
    end
  end

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_DECODE))
    else $error("accepted command not decoded");
  a_finish_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == S_IDLE))
    else $error("finish event did not end the command");
  a_last_only_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (cmd_o.last == (cmd_o.kind == KIND_FINISH)))
    else $error("last flag on a non-finish event");

endmodule

[hdl/job_admission_timeslice_scheduler.sv]
// Job admission and time-slice scheduler, top level.
// Instantiates jats_ctrl and jats_dp; types and constants from jats_pkg.
//
// Usage:
//  - Command channel: in_valid_i / in_stall_o with opcode_i, job_slot_i, block_count_i.
//    A command transfers at a clock edge with in_valid_i high and in_stall_o low.
//    Only one command is in flight; in_stall_o stays high until its finish event is taken
//    into the output register.
//  - Event channel: out_valid_o / out_stall_i with event_kind_o, event_slot_o, status_o,
//    last_o. Every command gives zero or more start/stop events, then one finish event
//    with last_o set. A stalled event holds in the output register; the controller waits.
//  - Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i; ready is
//    always high. Write only while no command is in flight.
//  - Sequencing: each job examined costs one walk of all slots through the slot memory read
//    port, plus a start try, or a slice-end check (two multiply stages and a compare) and a
//    stop step when the job is stopped. A tick with nothing pending makes one walk; enqueue
//    adds a free-slot search and the record write.
//  - Reset: all slots free, counters and time zero, registers at their reset values.
//    No memory clearing pass is needed.
module job_admission_timeslice_scheduler #(
  parameter int JOB_SLOTS = jats_pkg::JobSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  job_slot_i,
  input  logic [15:0] block_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [3:0]  event_slot_o,
  output logic [1:0]  status_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import jats_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready_o = 1'b1;

  jats_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  jats_dp #(
    .JOB_SLOTS (JOB_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (opcode_i),
    .job_slot_i    (job_slot_i),
    .block_count_i (block_count_i),
    .cfg_wr_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .event_slot_o  (event_slot_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule
